// ----- design/mavd_pkg.sv -----
// Package with the shared constants and types of the multichannel average decimator.
package mavd_pkg;

    localparam int CHANNELS     = 4;
    localparam int SAMPLE_BITS  = 10;
    localparam int MAX_AVG_LOG2 = 12;

    localparam int LG_W      = 4;
    localparam int CNT_W     = (MAX_AVG_LOG2 > 0) ? MAX_AVG_LOG2 : 1;
    localparam int SUM_W     = SAMPLE_BITS + MAX_AVG_LOG2;
    localparam int GAIN_W    = 26;
    localparam int GAIN_FRAC = 16;
    localparam int PROD_W    = SUM_W + GAIN_W;
    localparam int SCALED_W  = 20;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_AVG_LOG2 = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_CH0 = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_CH1 = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_CH2 = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAIN_CH3 = 3'd4;

    localparam logic [LG_W-1:0] AVG_LOG2_RESET = 4'd12;

    typedef logic [GAIN_W-1:0] gain_t;
    typedef gain_t [CHANNELS-1:0] gain_vec_t;

    localparam gain_vec_t GAIN_RESET = {26'd422813, 26'd2325471, 26'd35987883, 26'd3897491};

    typedef struct packed {
        logic            acc_en;
        logic            dump;
        logic            p2_load;
        logic            out_load;
        logic [LG_W-1:0] out_lg;
    } lane_ctrl_t;

endpackage

// ----- design/mavd_lane.sv -----
// One channel lane: running sum, gain multiply and window scaling.
module mavd_lane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mavd_pkg::lane_ctrl_t                  ctrl,
    input  logic [mavd_pkg::SAMPLE_BITS-1:0]      sample,
    input  logic [mavd_pkg::GAIN_W-1:0]           gain,
    output logic [mavd_pkg::SUM_W-1:0]            sum_out,
    output logic [mavd_pkg::SCALED_W-1:0]         scaled_out
);

    localparam int SH_W = mavd_pkg::PROD_W - mavd_pkg::GAIN_FRAC;

    logic [mavd_pkg::SUM_W-1:0]    acc_reg;
    logic [mavd_pkg::SUM_W-1:0]    acc_next;
    logic [mavd_pkg::SUM_W-1:0]    acc_sum;
    logic [mavd_pkg::SUM_W-1:0]    d1_sum_reg;
    logic [mavd_pkg::SUM_W-1:0]    d2_sum_reg;
    logic [mavd_pkg::PROD_W-1:0]   prod_reg;
    logic [mavd_pkg::SUM_W-1:0]    o_sum_reg;
    logic [mavd_pkg::SCALED_W-1:0] o_scaled_reg;
    logic [mavd_pkg::SCALED_W-1:0] o_scaled_next;
    logic [SH_W-1:0]               shifted;

    assign acc_sum = acc_reg + mavd_pkg::SUM_W'(sample);

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.acc_en) begin
            acc_next = ctrl.dump ? '0 : acc_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // The product keeps its integer part; the window length then shifts it down.
    always_comb begin
        shifted = prod_reg[mavd_pkg::PROD_W-1:mavd_pkg::GAIN_FRAC] >> ctrl.out_lg;
        if (|shifted[SH_W-1:mavd_pkg::SCALED_W]) begin
            o_scaled_next = '1;
        end else begin
            o_scaled_next = shifted[mavd_pkg::SCALED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.dump) begin
            d1_sum_reg <= acc_sum;
        end
        if (ctrl.p2_load) begin
            prod_reg   <= mavd_pkg::PROD_W'(d1_sum_reg) * mavd_pkg::PROD_W'(gain);
            d2_sum_reg <= d1_sum_reg;
        end
        if (ctrl.out_load) begin
            o_sum_reg    <= d2_sum_reg;
            o_scaled_reg <= o_scaled_next;
        end
    end

    assign sum_out    = o_sum_reg;
    assign scaled_out = o_scaled_reg;

endmodule

// ----- design/mavd_ctrl.sv -----
// Frame counter, window compare and pipeline handshake control shared by all lanes.
module mavd_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    output logic                            m_valid,
    input  logic                            m_ready,
    input  logic [mavd_pkg::LG_W-1:0]       avg_log2,
    output mavd_pkg::lane_ctrl_t            ctrl
);

    logic [mavd_pkg::CNT_W-1:0] cnt_reg;
    logic [mavd_pkg::CNT_W-1:0] cnt_next;
    logic [mavd_pkg::CNT_W:0]   cnt_inc;
    logic [mavd_pkg::CNT_W:0]   target;
    logic [mavd_pkg::LG_W-1:0]  lg_eff;
    logic [mavd_pkg::LG_W-1:0]  lg1_reg;
    logic [mavd_pkg::LG_W-1:0]  lg2_reg;
    logic                       v1_reg;
    logic                       v1_next;
    logic                       v2_reg;
    logic                       v2_next;
    logic                       vo_reg;
    logic                       vo_next;
    logic                       out_rdy;
    logic                       p2_rdy;
    logic                       p1_rdy;
    logic                       accept;
    logic                       dump;

    assign out_rdy = !vo_reg || m_ready;
    assign p2_rdy  = !v2_reg || out_rdy;
    assign p1_rdy  = !v1_reg || p2_rdy;
    assign s_ready = p1_rdy;
    assign accept  = s_valid && p1_rdy;
    assign m_valid = vo_reg;

    assign lg_eff  = (avg_log2 > mavd_pkg::LG_W'(mavd_pkg::MAX_AVG_LOG2))
                   ? mavd_pkg::LG_W'(mavd_pkg::MAX_AVG_LOG2) : avg_log2;
    assign target  = (mavd_pkg::CNT_W+1)'(1) << lg_eff;
    assign cnt_inc = {1'b0, cnt_reg} + (mavd_pkg::CNT_W+1)'(1);
    assign dump    = accept && (cnt_inc >= target);

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = dump ? '0 : cnt_inc[mavd_pkg::CNT_W-1:0];
        end
        v1_next = p1_rdy ? dump : v1_reg;
        v2_next = p2_rdy ? v1_reg : v2_reg;
        vo_next = out_rdy ? v2_reg : vo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            vo_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            vo_reg  <= vo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dump) begin
            lg1_reg <= lg_eff;
        end
        if (p2_rdy && v1_reg) begin
            lg2_reg <= lg1_reg;
        end
    end

    assign ctrl.acc_en   = accept;
    assign ctrl.dump     = dump;
    assign ctrl.p2_load  = p2_rdy && v1_reg;
    assign ctrl.out_load = out_rdy && v2_reg;
    assign ctrl.out_lg   = lg2_reg;

endmodule

// ----- design/multichannel_average_decimator_unit.sv -----
// Top level of the multichannel average decimator: registers, lanes and result merge.
//
//  Channel  Direction  Handshake           Beat contents
//  s_       in         s_valid / s_ready   one scan frame, four samples
//  m_       out        m_valid / m_ready   four window sums, four scaled averages
//  cfg_     in         cfg_wr_en           register index and write data
//
// One frame is accepted every cycle while s_ready is high; a frame that closes a window passes
// through the capture, multiply and scale stages to the result register.
// The per-lane 22 by 26 bit multiplier sets the stage depth.
// Reset clears the sums, the frame counter and the pipeline and loads the default gains.
// A stalled result holds the result stage; frames keep being taken until all three stages
// hold a result, and then the input waits until the result beat leaves.
module multichannel_average_decimator_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mavd_pkg::SAMPLE_BITS-1:0]      s_sample_ch0,
    input  logic [mavd_pkg::SAMPLE_BITS-1:0]      s_sample_ch1,
    input  logic [mavd_pkg::SAMPLE_BITS-1:0]      s_sample_ch2,
    input  logic [mavd_pkg::SAMPLE_BITS-1:0]      s_sample_ch3,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mavd_pkg::SUM_W-1:0]            m_sum_ch0,
    output logic [mavd_pkg::SUM_W-1:0]            m_sum_ch1,
    output logic [mavd_pkg::SUM_W-1:0]            m_sum_ch2,
    output logic [mavd_pkg::SUM_W-1:0]            m_sum_ch3,
    output logic [mavd_pkg::SCALED_W-1:0]         m_scaled_ch0,
    output logic [mavd_pkg::SCALED_W-1:0]         m_scaled_ch1,
    output logic [mavd_pkg::SCALED_W-1:0]         m_scaled_ch2,
    output logic [mavd_pkg::SCALED_W-1:0]         m_scaled_ch3,
    input  logic                                  cfg_wr_en,
    input  logic [mavd_pkg::IDX_W-1:0]            cfg_index,
    input  logic [mavd_pkg::GAIN_W-1:0]           cfg_wdata
);

    logic [mavd_pkg::LG_W-1:0]        avg_log2_reg;
    mavd_pkg::gain_vec_t              gain_reg;
    mavd_pkg::lane_ctrl_t             ctrl;
    logic [mavd_pkg::SAMPLE_BITS-1:0] samples [mavd_pkg::CHANNELS];
    logic [mavd_pkg::SUM_W-1:0]       sums    [mavd_pkg::CHANNELS];
    logic [mavd_pkg::SCALED_W-1:0]    scaled  [mavd_pkg::CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_log2_reg <= mavd_pkg::AVG_LOG2_RESET;
            gain_reg     <= mavd_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mavd_pkg::REG_AVG_LOG2: avg_log2_reg <= cfg_wdata[mavd_pkg::LG_W-1:0];
                mavd_pkg::REG_GAIN_CH0: gain_reg[0]  <= cfg_wdata;
                mavd_pkg::REG_GAIN_CH1: gain_reg[1]  <= cfg_wdata;
                mavd_pkg::REG_GAIN_CH2: gain_reg[2]  <= cfg_wdata;
                mavd_pkg::REG_GAIN_CH3: gain_reg[3]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mavd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .avg_log2 (avg_log2_reg),
        .ctrl     (ctrl)
    );

    assign samples[0] = s_sample_ch0;
    assign samples[1] = s_sample_ch1;
    assign samples[2] = s_sample_ch2;
    assign samples[3] = s_sample_ch3;

    for (genvar c = 0; c < mavd_pkg::CHANNELS; c++) begin : g_lane
        mavd_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .sample     (samples[c]),
            .gain       (gain_reg[c]),
            .sum_out    (sums[c]),
            .scaled_out (scaled[c])
        );
    end

    assign m_sum_ch0    = sums[0];
    assign m_sum_ch1    = sums[1];
    assign m_sum_ch2    = sums[2];
    assign m_sum_ch3    = sums[3];
    assign m_scaled_ch0 = scaled[0];
    assign m_scaled_ch1 = scaled[1];
    assign m_scaled_ch2 = scaled[2];
    assign m_scaled_ch3 = scaled[3];

endmodule

// ----- test/multichannel_average_decimator_unit_tb.sv -----
// Self-checking testbench for the multichannel average decimator: sums, scaling and handshakes.
module multichannel_average_decimator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_FRAMES = 63;

    localparam logic [mavd_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam mavd_pkg::gain_t                  GAIN_MAX   = '1;
    localparam logic [mavd_pkg::SCALED_W-1:0]    SCALED_MAX = '1;

    typedef logic [mavd_pkg::CHANNELS-1:0][mavd_pkg::SAMPLE_BITS-1:0] frame_t;

    typedef struct packed {
        logic [mavd_pkg::CHANNELS-1:0][mavd_pkg::SUM_W-1:0]    sums;
        logic [mavd_pkg::CHANNELS-1:0][mavd_pkg::SCALED_W-1:0] scaled;
    } window_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                             s_valid      = 1'b0;
    logic                             s_ready;
    logic [mavd_pkg::SAMPLE_BITS-1:0] s_sample_ch0 = '0;
    logic [mavd_pkg::SAMPLE_BITS-1:0] s_sample_ch1 = '0;
    logic [mavd_pkg::SAMPLE_BITS-1:0] s_sample_ch2 = '0;
    logic [mavd_pkg::SAMPLE_BITS-1:0] s_sample_ch3 = '0;
    logic                             m_valid;
    logic                             m_ready      = 1'b0;
    logic [mavd_pkg::SUM_W-1:0]       m_sum_ch0;
    logic [mavd_pkg::SUM_W-1:0]       m_sum_ch1;
    logic [mavd_pkg::SUM_W-1:0]       m_sum_ch2;
    logic [mavd_pkg::SUM_W-1:0]       m_sum_ch3;
    logic [mavd_pkg::SCALED_W-1:0]    m_scaled_ch0;
    logic [mavd_pkg::SCALED_W-1:0]    m_scaled_ch1;
    logic [mavd_pkg::SCALED_W-1:0]    m_scaled_ch2;
    logic [mavd_pkg::SCALED_W-1:0]    m_scaled_ch3;
    logic                             cfg_wr_en    = 1'b0;
    logic [mavd_pkg::IDX_W-1:0]       cfg_index    = '0;
    logic [mavd_pkg::GAIN_W-1:0]      cfg_wdata    = '0;

    logic [mavd_pkg::CHANNELS-1:0][mavd_pkg::SUM_W-1:0]    got_sums;
    logic [mavd_pkg::CHANNELS-1:0][mavd_pkg::SCALED_W-1:0] got_scaled;

    assign got_sums   = {m_sum_ch3, m_sum_ch2, m_sum_ch1, m_sum_ch0};
    assign got_scaled = {m_scaled_ch3, m_scaled_ch2, m_scaled_ch1, m_scaled_ch0};

    logic [mavd_pkg::LG_W-1:0]  window_log2  = mavd_pkg::AVG_LOG2_RESET;
    mavd_pkg::gain_vec_t        channel_gain = mavd_pkg::GAIN_RESET;
    logic [mavd_pkg::CHANNELS-1:0][mavd_pkg::SUM_W-1:0] running_sum = '0;
    int                         frames_in_window = 0;
    window_result_t             pending_windows[$];

    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_requests  = 0;
    int          hold_served    = 0;
    int          hold_left      = 0;
    int unsigned cycle_count    = 0;
    window_result_t oldest;

    multichannel_average_decimator_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_ch0 (s_sample_ch0),
        .s_sample_ch1 (s_sample_ch1),
        .s_sample_ch2 (s_sample_ch2),
        .s_sample_ch3 (s_sample_ch3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sum_ch0    (m_sum_ch0),
        .m_sum_ch1    (m_sum_ch1),
        .m_sum_ch2    (m_sum_ch2),
        .m_sum_ch3    (m_sum_ch3),
        .m_scaled_ch0 (m_scaled_ch0),
        .m_scaled_ch1 (m_scaled_ch1),
        .m_scaled_ch2 (m_scaled_ch2),
        .m_scaled_ch3 (m_scaled_ch3),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("multichannel_average_decimator_unit_tb NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_windows.size() == 0) begin
                $error("result beat with no window pending");
                mismatches++;
            end else begin
                oldest = pending_windows.pop_front();
                for (int c = 0; c < mavd_pkg::CHANNELS; c++) begin
                    check_field($sformatf("sum_ch%0d", c), oldest.sums[c], got_sums[c]);
                    check_field($sformatf("scaled_ch%0d", c), oldest.scaled[c],
                                got_scaled[c]);
                end
            end
        end
    end

    function automatic void accumulate_frame(frame_t frame);
        logic [mavd_pkg::LG_W-1:0] lg;
        logic [63:0]               product;
        window_result_t            window;
        lg = (window_log2 > mavd_pkg::MAX_AVG_LOG2)
           ? mavd_pkg::LG_W'(mavd_pkg::MAX_AVG_LOG2) : window_log2;
        for (int c = 0; c < mavd_pkg::CHANNELS; c++) begin
            running_sum[c] = running_sum[c] + mavd_pkg::SUM_W'(frame[c]);
        end
        if (frames_in_window + 1 < (1 << lg)) begin
            frames_in_window++;
        end else begin
            for (int c = 0; c < mavd_pkg::CHANNELS; c++) begin
                product = 64'(running_sum[c]) * 64'(channel_gain[c]);
                product = product >> (lg + mavd_pkg::GAIN_FRAC);
                window.sums[c]   = running_sum[c];
                window.scaled[c] = (product > 64'(SCALED_MAX))
                                 ? SCALED_MAX : product[mavd_pkg::SCALED_W-1:0];
            end
            pending_windows.push_back(window);
            running_sum      = '0;
            frames_in_window = 0;
        end
    endfunction

    task automatic write_reg(logic [mavd_pkg::IDX_W-1:0] index,
                             logic [mavd_pkg::GAIN_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
        case (index)
            mavd_pkg::REG_AVG_LOG2: window_log2     = data[mavd_pkg::LG_W-1:0];
            mavd_pkg::REG_GAIN_CH0: channel_gain[0] = data;
            mavd_pkg::REG_GAIN_CH1: channel_gain[1] = data;
            mavd_pkg::REG_GAIN_CH2: channel_gain[2] = data;
            mavd_pkg::REG_GAIN_CH3: channel_gain[3] = data;
            default: ;
        endcase
    endtask

    task automatic configure(logic [mavd_pkg::GAIN_W-1:0] avg_data,
                             mavd_pkg::gain_vec_t gains);
        write_reg(mavd_pkg::REG_AVG_LOG2, avg_data);
        write_reg(mavd_pkg::REG_GAIN_CH0, gains[0]);
        write_reg(mavd_pkg::REG_GAIN_CH1, gains[1]);
        write_reg(mavd_pkg::REG_GAIN_CH2, gains[2]);
        write_reg(mavd_pkg::REG_GAIN_CH3, gains[3]);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame(frame_t frame);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_sample_ch0 <= frame[0];
        s_sample_ch1 <= frame[1];
        s_sample_ch2 <= frame[2];
        s_sample_ch3 <= frame[3];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accumulate_frame(frame);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [mavd_pkg::SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return mavd_pkg::SAMPLE_BITS'($urandom_range(0,
                                                   2**mavd_pkg::SAMPLE_BITS - 1));
        endcase
    endfunction

    function automatic frame_t random_frame();
        frame_t frame;
        for (int c = 0; c < mavd_pkg::CHANNELS; c++) frame[c] = random_sample();
        return frame;
    endfunction

    function automatic mavd_pkg::gain_vec_t random_gains();
        mavd_pkg::gain_vec_t gains;
        for (int c = 0; c < mavd_pkg::CHANNELS; c++) begin
            case ($urandom_range(7))
                0:       gains[c] = '0;
                1:       gains[c] = GAIN_MAX;
                default: gains[c] = mavd_pkg::GAIN_W'($urandom_range(0,
                                                      2**mavd_pkg::GAIN_W - 1));
            endcase
        end
        return gains;
    endfunction

    task automatic test_reset_defaults();
        for (int i = 0; i < 60; i++) send_frame(random_frame());
        drain();
        write_reg(mavd_pkg::REG_AVG_LOG2, 26'd2);
        cfg_wr_en <= 1'b0;
        send_frame(random_frame());
        drain();
    endtask

    task automatic test_field_extremes();
        configure('0, {GAIN_MAX, 26'd65536, GAIN_MAX, 26'd0});
        send_frame('0);
        send_frame({SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
        send_frame({10'h155, 10'h155, 10'h155, 10'h155});
        send_frame({10'h2AA, 10'h2AA, 10'h2AA, 10'h2AA});
        send_frame({10'h000, 10'h3FF, 10'h200, 10'h001});
        send_frame({10'h001, 10'h200, 10'h3FF, 10'h000});
        drain();
        configure(26'h3FFFFF1, {26'd0, GAIN_MAX, 26'd1, 26'd65536});
        send_frame({SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
        send_frame({SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
        send_frame({10'h2AA, 10'h155, 10'h2AA, 10'h155});
        send_frame({10'h155, 10'h2AA, 10'h155, 10'h2AA});
        drain();
        for (int index = mavd_pkg::CHANNELS + 1; index < 2**mavd_pkg::IDX_W; index++) begin
            write_reg(mavd_pkg::IDX_W'(index), GAIN_MAX);
        end
        cfg_wr_en <= 1'b0;
        send_frame({10'h3FF, 10'h000, 10'h3FF, 10'h000});
        send_frame({10'h000, 10'h3FF, 10'h000, 10'h3FF});
        drain();
    endtask

    task automatic test_long_window();
        configure(26'd15, {GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX});
        for (int i = 0; i < 40; i++) begin
            send_frame({SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
        end
        drain();
        write_reg(mavd_pkg::REG_AVG_LOG2, 26'd0);
        cfg_wr_en <= 1'b0;
        send_frame({SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
        drain();
    endtask

    task automatic test_window_shortened();
        configure(26'd6, {GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX});
        for (int i = 0; i < 63; i++) send_frame({SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
        drain();
        write_reg(mavd_pkg::REG_AVG_LOG2, 26'd0);
        cfg_wr_en <= 1'b0;
        send_frame({SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
        drain();
        configure(26'd3, {26'd3897491, 26'd35987883, 26'd2325471, 26'd422813});
        for (int i = 0; i < 5; i++) send_frame(random_frame());
        drain();
        write_reg(mavd_pkg::REG_AVG_LOG2, 26'd2);
        cfg_wr_en <= 1'b0;
        send_frame(random_frame());
        send_frame(random_frame());
        drain();
    endtask

    task automatic test_random_traffic();
        int idle_modes[4]  = '{0, 65, 0, 31};
        int stall_modes[4] = '{0, 0, 65, 31};
        logic [mavd_pkg::GAIN_W-1:0] avg_data;
        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct  = idle_modes[mode];
            recv_stall_pct = stall_modes[mode];
            for (int part = 0; part < 2; part++) begin
                case ($urandom_range(9))
                    7, 8:    avg_data = mavd_pkg::GAIN_W'($urandom_range(4, 6));
                    9:       avg_data = mavd_pkg::GAIN_W'($urandom_range(12, 15));
                    default: avg_data = mavd_pkg::GAIN_W'($urandom_range(0, 3));
                endcase
                configure(avg_data, random_gains());
                for (int i = 0; i < RANDOM_FRAMES; i++) send_frame(random_frame());
                drain();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        configure('0, random_gains());
        hold_requests++;
        for (int i = 0; i < 40; i++) send_frame(random_frame());
        for (int i = 0; i < 10; i++) send_frame(random_frame());
        drain();
        configure(26'd1, random_gains());
        recv_stall_pct = 31;
        hold_requests++;
        for (int i = 0; i < 60; i++) send_frame(random_frame());
        drain();
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_field_extremes();
        test_long_window();
        test_window_shortened();
        test_random_traffic();
        test_backpressure();
        drain();
        if (mismatches == 0 && pending_windows.size() == 0) begin
            $display("multichannel_average_decimator_unit_tb OK");
        end else begin
            $display("multichannel_average_decimator_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
